// File: rtl/periodic_timer_set_scan_macros.svh
// Assertion macros for the checker file of the timer bank.
`ifndef PERIODIC_TIMER_SET_SCAN_MACROS_SVH
`define PERIODIC_TIMER_SET_SCAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pts: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pts: next-cycle check failed");

`endif

// File: rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    localparam logic [2:0] CMD_SCAN    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_TIMEOUT = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [30:0] value;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         fired_slot;
        logic [31:0]        miss_count;
        logic signed [31:0] next_delay;
        logic               running;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [30:0] period;
        logic [31:0] deadline;
    } entry_t;

    typedef struct packed {
        logic   en;
        logic   armed;
        entry_t entry;
    } store_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DIV,
        S_FIRE,
        S_MIN,
        S_NEXT,
        S_DONE,
        S_ACK
    } state_t;

endpackage

`default_nettype wire

// File: rtl/periodic_timer_set_scan.sv
// Channel   Dir   Payload   Handshake
// req       in    req_t     req_valid / req_stall
// rsp       out   rsp_t     rsp_valid / rsp_stall
//
// A command other than scan is read, evaluated and acknowledged; set_restart with a nonzero
// period also runs the serial divider. A scan reads, evaluates and steps past each slot, plus
// a min step per armed slot, a fire step per firing one and a 32-bit divide per periodic one.
// Reset clears the armed flags and the entry valid bits; there is no clearing pass.
// A stalled response holds the sequencer; req_stall is high until the last beat is registered.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_set_scan
    import pts_pkg::*;
#(
    parameter int TIMERS = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_stall,
    input  wire req_t   req,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output rsp_t        rsp
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic [IW-1:0] addr;
    store_wr_t     wr;
    entry_t        rd_entry;
    logic          rd_armed;
    logic          div_start;
    logic [31:0]   div_dividend;
    logic [30:0]   div_divisor;
    logic          div_done;
    logic [31:0]   div_quo;
    logic [30:0]   div_rem;

    pts_store #(
        .TIMERS (TIMERS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (addr),
        .wr       (wr),
        .rd_entry (rd_entry),
        .rd_armed (rd_armed)
    );

    pts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    pts_seq #(
        .TIMERS (TIMERS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .addr         (addr),
        .wr           (wr),
        .rd_entry     (rd_entry),
        .rd_armed     (rd_armed),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quo      (div_quo),
        .div_rem      (div_rem)
    );

endmodule

`default_nettype wire

// File: rtl/pts_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_div
    import pts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [30:0]      remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [30:0] rem_reg;
    logic [30:0] dvs_reg;
    logic [31:0] shifted;
    logic [31:0] trial;
    logic        ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        ge      = (shifted >= {1'b0, dvs_reg});
        trial   = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? trial[30:0] : shifted[30:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/pts_store.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_store
    import pts_pkg::*;
#(
    parameter int TIMERS = 8,
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [IW-1:0]   addr,
    input  wire store_wr_t       wr,
    output entry_t               rd_entry,
    output logic                 rd_armed
);

    entry_t              mem [TIMERS];
    entry_t              rd_data_reg;
    logic [TIMERS-1:0]   valid_reg;
    logic [TIMERS-1:0]   armed_reg;
    logic                rd_valid_reg;
    logic                rd_armed_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[addr] <= wr.entry;
        end
        rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            armed_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_armed_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[addr];
            rd_armed_reg <= armed_reg[addr];
            if (wr.en)
            begin
                valid_reg[addr] <= 1'b1;
                armed_reg[addr] <= wr.armed;
            end
        end
    end

    // An entry never written reads as zero, as after reset.
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;
    assign rd_armed = rd_armed_reg;

endmodule

`default_nettype wire

// File: rtl/pts_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_seq
    import pts_pkg::*;
#(
    parameter int TIMERS = 8,
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire req_t          req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output rsp_t               rsp,
    output logic [IW-1:0]      addr,
    output store_wr_t          wr,
    input  wire entry_t        rd_entry,
    input  wire logic          rd_armed,
    output logic               div_start,
    output logic [31:0]        div_dividend,
    output logic [30:0]        div_divisor,
    input  wire logic          div_done,
    input  wire logic [31:0]   div_quo,
    input  wire logic [30:0]   div_rem
);

    localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

    state_t         state_reg, state_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [2:0]     slot_reg, slot_next;
    logic [30:0]    value_reg, value_next;
    logic [31:0]    now_reg, now_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           run_reg, run_next;
    logic [31:0]    cnt_reg, cnt_next;
    logic [31:0]    t_reg, t_next;
    logic [31:0]    best_reg, best_next;
    logic           have_reg, have_next;
    logic [30:0]    p_reg, p_next;
    logic           eneg_reg, eneg_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    logic           is_scan;
    logic           req_oor;
    logic [31:0]    diff;
    logic           expired;
    logic [31:0]    mag;
    logic [31:0]    now_plus_value;
    logic [31:0]    base;
    logic [31:0]    new_deadline;
    logic [31:0]    tdiff;
    logic [31:0]    bdiff;
    logic           take;
    logic           rsp_free;
    logic           emit;
    rsp_t           emit_rsp;

    always_comb
    begin
        is_scan        = (cmd_reg == CMD_SCAN);
        req_oor        = (req.cmd != CMD_SCAN) && (32'(req.slot) >= 32'(TIMERS));
        diff           = rd_entry.deadline - now_reg;
        expired        = diff[31] || (diff == 32'd0);
        mag            = expired ? (32'd0 - diff) : diff;
        now_plus_value = now_reg + {1'b0, value_reg};
        base           = now_reg + {1'b0, p_reg};
        // The catch-up step lands on now plus a period, less or plus the remainder.
        new_deadline   = eneg_reg ? (base + {1'b0, div_rem}) : (base - {1'b0, div_rem});
        tdiff          = t_reg - now_reg;
        bdiff          = t_reg - best_reg;
        take           = !tdiff[31] && (!have_reg || bdiff[31]);
        rsp_free       = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_oor ? S_ACK : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (cmd_reg)
                    CMD_SCAN:
                    begin
                        if (!rd_armed)
                        begin
                            state_next = S_NEXT;
                        end
                        else if (expired)
                        begin
                            state_next = (rd_entry.period != '0) ? S_DIV : S_FIRE;
                        end
                        else
                        begin
                            state_next = S_MIN;
                        end
                    end
                    CMD_RESTART:
                    begin
                        state_next = (value_reg != '0) ? S_DIV : S_ACK;
                    end
                    default:
                    begin
                        state_next = S_ACK;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = is_scan ? S_FIRE : S_ACK;
                end
            end
            S_FIRE:
            begin
                if (rsp_free)
                begin
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = (idx_reg == LAST_IDX) ? S_DONE : S_READ;
            end
            S_DONE, S_ACK:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall    = (state_reg != S_IDLE);
        addr         = idx_reg;
        div_dividend = mag;
        div_divisor  = is_scan ? rd_entry.period : value_reg;
        div_start    = 1'b0;
        wr           = '0;
        emit         = 1'b0;
        emit_rsp     = '0;
        case (state_reg)
            S_EVAL:
            begin
                case (cmd_reg)
                    CMD_SCAN:
                    begin
                        if (rd_armed && expired)
                        begin
                            if (rd_entry.period != '0)
                            begin
                                div_start = 1'b1;
                            end
                            else
                            begin
                                wr.en    = 1'b1;
                                wr.armed = 1'b0;
                                wr.entry = rd_entry;
                            end
                        end
                    end
                    CMD_START:
                    begin
                        wr.en             = 1'b1;
                        wr.armed          = (value_reg != '0);
                        wr.entry.period   = value_reg;
                        wr.entry.deadline = now_plus_value;
                    end
                    CMD_TIMEOUT:
                    begin
                        wr.en             = 1'b1;
                        wr.armed          = 1'b1;
                        wr.entry.period   = rd_entry.period;
                        wr.entry.deadline = now_plus_value;
                    end
                    CMD_RESTART:
                    begin
                        if (value_reg != '0)
                        begin
                            div_start = 1'b1;
                        end
                        else
                        begin
                            wr.en             = 1'b1;
                            wr.armed          = 1'b0;
                            wr.entry.period   = '0;
                            wr.entry.deadline = rd_entry.deadline;
                        end
                    end
                    default:
                    begin
                        wr = '0;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr.en             = 1'b1;
                    wr.armed          = 1'b1;
                    wr.entry.period   = p_reg;
                    wr.entry.deadline = new_deadline;
                end
            end
            S_FIRE:
            begin
                emit                = rsp_free;
                emit_rsp.kind       = KIND_FIRED;
                emit_rsp.fired_slot = 3'(idx_reg);
                emit_rsp.miss_count = cnt_reg;
                emit_rsp.running    = run_reg;
            end
            S_DONE:
            begin
                emit                = rsp_free;
                emit_rsp.kind       = KIND_DONE;
                emit_rsp.next_delay = have_reg ? signed'(best_reg - now_reg) : -32'sd1;
                emit_rsp.last       = 1'b1;
            end
            S_ACK:
            begin
                emit                = rsp_free;
                emit_rsp.kind       = KIND_ACK;
                emit_rsp.fired_slot = slot_reg;
                emit_rsp.running    = run_reg;
                emit_rsp.last       = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        p_next         = p_reg;
        eneg_next      = eneg_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_rsp;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    slot_next  = req.slot;
                    value_next = req.value;
                    now_next   = req.now;
                    idx_next   = (req.cmd == CMD_SCAN || req_oor) ? '0 : IW'(req.slot);
                    have_next  = 1'b0;
                    run_next   = 1'b0;
                end
            end
            S_EVAL:
            begin
                p_next    = is_scan ? rd_entry.period : value_reg;
                eneg_next = !expired;
                t_next    = rd_entry.deadline;
                cnt_next  = 32'd1;
                case (cmd_reg)
                    CMD_SCAN:
                    begin
                        run_next = 1'b0;
                    end
                    CMD_START, CMD_RESTART:
                    begin
                        run_next = (value_reg != '0);
                    end
                    CMD_TIMEOUT:
                    begin
                        run_next = 1'b1;
                    end
                    CMD_QUERY:
                    begin
                        run_next = rd_armed;
                    end
                    default:
                    begin
                        run_next = rd_armed;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next   = new_deadline;
                    cnt_next = div_quo + 32'd1;
                    run_next = 1'b1;
                end
            end
            S_MIN:
            begin
                if (take)
                begin
                    best_next = t_reg;
                    have_next = 1'b1;
                end
            end
            S_NEXT:
            begin
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
        now_reg   <= now_next;
        idx_reg   <= idx_next;
        run_reg   <= run_next;
        cnt_reg   <= cnt_next;
        t_reg     <= t_next;
        best_reg  <= best_next;
        have_reg  <= have_next;
        p_reg     <= p_next;
        eneg_reg  <= eneg_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/pts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_timer_set_scan_macros.svh"

module pts_checker
    import pts_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // A fired beat is never the last of its item; every other kind is.
    `PTS_ASSERT_NOW(a_last_kind, clk, rst_n, rsp_valid, rsp.last == (rsp.kind != KIND_FIRED))

    // A fired slot has missed at least one period.
    `PTS_ASSERT_NOW(a_fired_count, clk, rst_n, rsp_valid && (rsp.kind == KIND_FIRED), rsp.miss_count != 32'd0)

    // The bank works on one item at a time.
    `PTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    `PTS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind periodic_timer_set_scan pts_checker u_pts_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    localparam int NUM_TIMERS = 8;
    localparam int RANDOM_ITEMS = 350;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SQUEEZE_AT = 150;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
    localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_reqs[$];
    rsp_t expected_results[$];

    logic [31:0] slot_deadline [NUM_TIMERS];
    logic [30:0] slot_period [NUM_TIMERS];
    logic slot_armed [NUM_TIMERS];

    logic req_fire = 1'b0;
    int total_items = 0;
    int items_sent = 0;
    int scans_seen = 0;
    int firings_seen = 0;
    int results_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int hold_left = 0;
    bit squeeze_done = 1'b0;

    periodic_timer_set_scan #(
        .TIMERS(NUM_TIMERS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 94)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic longint reload_slot(int s, logic [31:0] now_ms);
        logic [31:0] lag;
        longint overdue;
        longint span;
        longint periods;
        if (slot_period[s] == '0)
        begin
            slot_armed[s] = 1'b0;
            return 1;
        end
        lag = slot_deadline[s] - now_ms;
        overdue = -longint'($signed(lag));
        span = slot_period[s];
        periods = 1 + overdue / span;
        slot_armed[s] = 1'b1;
        slot_deadline[s] = slot_deadline[s] + 32'(span * periods);
        return periods;
    endfunction

    task automatic predict_command(req_t r);
        logic [31:0] best;
        logic [31:0] t;
        bit have;
        int ahead;
        int nearer;
        longint missed;
        rsp_t e;
        if (r.cmd == CMD_SCAN)
        begin
            have = 1'b0;
            best = '0;
            scans_seen++;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (slot_armed[i])
                begin
                    t = slot_deadline[i];
                    ahead = t - r.now;
                    if (ahead <= 0)
                    begin
                        missed = reload_slot(i, r.now);
                        e = '0;
                        e.kind = KIND_FIRED;
                        e.fired_slot = i[2:0];
                        e.miss_count = missed[31:0];
                        e.running = slot_armed[i];
                        expected_results.push_back(e);
                        firings_seen++;
                        t = slot_deadline[i];
                    end
                    ahead = t - r.now;
                    nearer = t - best;
                    if (ahead >= 0 && (!have || nearer < 0))
                    begin
                        best = t;
                        have = 1'b1;
                    end
                end
            end
            e = '0;
            e.kind = KIND_DONE;
            e.next_delay = have ? best - r.now : NO_DEADLINE;
            e.last = 1'b1;
            expected_results.push_back(e);
        end
        else
        begin
            case (r.cmd)
                CMD_START:
                begin
                    slot_period[r.slot] = r.value;
                    slot_deadline[r.slot] = r.now;
                    slot_armed[r.slot] = (r.value != '0);
                    void'(reload_slot(r.slot, r.now));
                end
                CMD_TIMEOUT:
                begin
                    slot_deadline[r.slot] = r.now + r.value;
                    slot_armed[r.slot] = 1'b1;
                end
                CMD_RESTART:
                begin
                    slot_period[r.slot] = r.value;
                    void'(reload_slot(r.slot, r.now));
                end
                default:
                begin
                end
            endcase
            e = '0;
            e.kind = KIND_ACK;
            e.fired_slot = r.slot;
            e.running = slot_armed[r.slot];
            e.last = 1'b1;
            expected_results.push_back(e);
        end
    endtask

    task automatic add_cmd(logic [2:0] cmd, logic [2:0] slot, logic [30:0] value,
                           logic [31:0] now);
        req_t r;
        r.cmd = cmd;
        r.slot = slot;
        r.value = value;
        r.now = now;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [30:0] pick_value();
        int roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        raw = $urandom;
        if (roll < 15)
        begin
            return '0;
        end
        if (roll < 60)
        begin
            return 31'($urandom_range(1, 60));
        end
        if (roll < 75)
        begin
            return 31'($urandom_range(61, 2000));
        end
        if (roll < 92)
        begin
            return raw[30:0];
        end
        return 31'h7FFF_FFFF;
    endfunction

    task automatic add_random_commands();
        logic [31:0] clock_ms;
        logic [2:0] cmd;
        int roll;
        clock_ms = 32'hFFFF_FF00;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                clock_ms = $urandom;
            end
            else if (roll < 7)
            begin
                clock_ms = clock_ms + $urandom_range(100, 5000);
            end
            else
            begin
                clock_ms = clock_ms + $urandom_range(0, 30);
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                cmd = CMD_SCAN;
            end
            else if (roll < 55)
            begin
                cmd = CMD_START;
            end
            else if (roll < 70)
            begin
                cmd = CMD_TIMEOUT;
            end
            else if (roll < 85)
            begin
                cmd = CMD_RESTART;
            end
            else if (roll < 95)
            begin
                cmd = CMD_QUERY;
            end
            else
            begin
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
            add_cmd(cmd, 3'($urandom_range(0, NUM_TIMERS - 1)), pick_value(), clock_ms);
        end
    endtask

    always @(posedge clk)
    begin
        req_fire <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            predict_command(req);
            items_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (req_fire || !req_valid))
        begin
            if (req_fire && (items_sent % 64) >= 12 && $urandom_range(0, 99) < 40)
            begin
                send_gap = idle_length();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // The long hold-off part-way through lets the block back up into its request side.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!squeeze_done && items_sent >= SQUEEZE_AT)
            begin
                squeeze_done = 1'b1;
                hold_left = SQUEEZE_CYCLES;
            end
            else if (hold_left == 0 && cycle_count[12:11] != 2'b00 &&
                     $urandom_range(0, 99) < 30)
            begin
                hold_left = idle_length();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Each response beat is checked against the oldest outstanding prediction.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected beat: kind %0d slot %0d miss %0d delay %0d",
                             rsp.kind, rsp.fired_slot, rsp.miss_count, rsp.next_delay);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.kind !== want.kind || rsp.fired_slot !== want.fired_slot ||
                    rsp.miss_count !== want.miss_count ||
                    rsp.next_delay !== want.next_delay ||
                    rsp.running !== want.running || rsp.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Beat %0d expected kind %0d slot %0d miss %0d delay %0d run %0b last %0b",
                                 results_checked, want.kind, want.fired_slot, want.miss_count,
                                 want.next_delay, want.running, want.last);
                        $display("        got      kind %0d slot %0d miss %0d delay %0d run %0b last %0b",
                                 rsp.kind, rsp.fired_slot, rsp.miss_count, rsp.next_delay,
                                 rsp.running, rsp.last);
                    end
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("[periodic_timer_set_scan] ERROR");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            slot_deadline[i] = '0;
            slot_period[i] = '0;
            slot_armed[i] = 1'b0;
        end

        add_cmd(CMD_SCAN, 3'd0, 31'd0, 32'd0);
        add_cmd(CMD_QUERY, 3'd0, 31'd0, 32'd0);
        add_cmd(CMD_START, 3'd0, 31'd0, 32'd5);
        add_cmd(CMD_START, 3'd1, 31'd10, 32'd0);
        add_cmd(CMD_TIMEOUT, 3'd2, 31'd0, 32'd0);
        add_cmd(CMD_SCAN, 3'd0, 31'd0, 32'd0);
        add_cmd(CMD_START, 3'd7, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(CMD_TIMEOUT, 3'd3, 31'h7FFF_FFFF, 32'd100);
        add_cmd(CMD_SCAN, 3'd5, 31'h7FFF_FFFF, 32'd35);
        add_cmd(CMD_RESTART, 3'd1, 31'd2, 32'd35);
        add_cmd(CMD_RESTART, 3'd4, 31'd0, 32'd35);
        add_cmd(CMD_RESTART, 3'd5, 31'd7, 32'd50);
        add_cmd(CMD_TIMEOUT, 3'd1, 31'd5, 32'd60);
        add_cmd(CMD_START, 3'd6, 31'd1, 32'd0);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
        begin
            add_cmd(3'(c), 3'(c), 31'(c), 32'd70);
        end
        add_cmd(CMD_SCAN, 3'd0, 31'd0, 32'h8000_0001);
        add_cmd(CMD_TIMEOUT, 3'd0, 31'h5555_5555, 32'hAAAA_AAAA);
        add_cmd(CMD_SCAN, 3'd7, 31'd0, 32'hFFFF_FFFF);
        add_cmd(CMD_RESTART, 3'd2, 31'h7FFF_FFFF, 32'd0);
        add_cmd(CMD_QUERY, 3'd3, 31'd0, 32'd0);
        add_random_commands();
        total_items = pending_reqs.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (items_sent == total_items);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run sent %0d commands, %0d of them scans, with %0d timer expiries predicted.",
                 items_sent, scans_seen, firings_seen);
        $display("%0d response beats compared, %0d mismatching.", results_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("[periodic_timer_set_scan] OK");
        end
        else
        begin
            $display("[periodic_timer_set_scan] ERROR");
        end
        $finish;
    end

endmodule
